@@ hw/rtl/xoodoo_pkg.sv @@
// Shared types, constants and the round constant schedule of the Xoodoo permutation.
package xoodoo_pkg;

  localparam int LaneW       = 32;
  localparam int NumLanes    = 12;
  localparam int NumCols     = 4;
  localparam int ScheduleLen = 12;
  localparam int MaxRoundsDef = 12;
  localparam int RoundCntW   = 4;
  localparam int WordW       = 64;

  typedef logic [LaneW-1:0] lane_t;
  typedef lane_t [NumLanes-1:0] lanes_t;
  typedef logic [RoundCntW-1:0] round_cnt_t;

  // Round constants, in the order the rounds use them.
  localparam lane_t RoundConsts [ScheduleLen] = '{
    32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
    32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
    32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
  };

  // One input beat: two lanes per word, the even lane in the low half.
  typedef struct packed {
    logic [WordW-1:0] state_words_01;
    logic [WordW-1:0] state_words_23;
    logic [WordW-1:0] state_words_45;
    logic [WordW-1:0] state_words_67;
    logic [WordW-1:0] state_words_89;
    logic [WordW-1:0] state_words_ab;
  } state_beat_t;

  // One result beat, packed the same way as the input.
  typedef struct packed {
    logic [WordW-1:0] perm_words_01;
    logic [WordW-1:0] perm_words_23;
    logic [WordW-1:0] perm_words_45;
    logic [WordW-1:0] perm_words_67;
    logic [WordW-1:0] perm_words_89;
    logic [WordW-1:0] perm_words_ab;
  } perm_beat_t;

endpackage

@@ hw/rtl/xoodoo_round.sv @@
// One Xoodoo round (theta, rho-west, iota, chi, rho-east) with a pass-through when disabled.
module xoodoo_round
  import xoodoo_pkg::*;
(
  input  lanes_t lanes_i,
  input  lane_t  rc_i,
  input  logic   en_i,
  output lanes_t lanes_o
);

  function automatic lane_t rotl(lane_t v, int unsigned n);
    return (v << n) | (v >> (LaneW - n));
  endfunction

  lane_t  parity [NumCols];
  lane_t  effect [NumCols];
  lanes_t mixed;
  lanes_t west;
  lanes_t chied;
  lanes_t east;

  always_comb begin
    // Theta: each column takes the rotated parity of the column to its left.
    for (int c = 0; c < NumCols; c++) begin
      parity[c] = lanes_i[c] ^ lanes_i[NumCols + c] ^ lanes_i[2*NumCols + c];
    end
    for (int c = 0; c < NumCols; c++) begin
      effect[c] = rotl(parity[(c + 3) & 3], 5) ^ rotl(parity[(c + 3) & 3], 14);
    end
    for (int c = 0; c < NumCols; c++) begin
      mixed[c]             = lanes_i[c] ^ effect[c];
      mixed[NumCols + c]   = lanes_i[NumCols + c] ^ effect[c];
      mixed[2*NumCols + c] = lanes_i[2*NumCols + c] ^ effect[c];
    end

    // Rho-west.
    for (int c = 0; c < NumCols; c++) begin
      west[c]             = mixed[c];
      west[NumCols + c]   = mixed[NumCols + ((c + 3) & 3)];
      west[2*NumCols + c] = rotl(mixed[2*NumCols + c], 11);
    end

    // Iota.
    west[0] = west[0] ^ rc_i;

    // Chi across the three planes.
    for (int c = 0; c < NumCols; c++) begin
      chied[c]             = west[c] ^ (~west[NumCols + c] & west[2*NumCols + c]);
      chied[NumCols + c]   = west[NumCols + c] ^ (~west[2*NumCols + c] & west[c]);
      chied[2*NumCols + c] = west[2*NumCols + c] ^ (~west[c] & west[NumCols + c]);
    end

    // Rho-east.
    for (int c = 0; c < NumCols; c++) begin
      east[c]             = chied[c];
      east[NumCols + c]   = rotl(chied[NumCols + c], 1);
      east[2*NumCols + c] = rotl(chied[2*NumCols + ((c + 2) & 3)], 8);
    end

    lanes_o = en_i ? east : lanes_i;
  end

endmodule

@@ hw/rtl/xoodoo_permutation.sv @@
// Top level of the Xoodoo permutation: beat registers around a fully unrolled round chain.
//
// Usage:
// A state beat is taken at a rising edge where start is high and busy is low.
// busy never rises: the block takes a new beat in every cycle.
// The beat lands in an input register together with the round count.
// MAX_ROUNDS round stages sit between that register and the result register.
// Stages before the last round_count ones pass the state through unchanged.
// The result beat appears on perm_o with done_o high for exactly one cycle.
// On its way there it passes through the input register and then the result register.
// Throughput is one beat per cycle; the round chain is the longest path.
// The receiver cannot stall; every result is shown once and must be taken.
// round_count is written through cfg_we_i/cfg_wdata_i; the user must write it only
// while idle, as the block does not enforce this. Values above MAX_ROUNDS are
// saturated to MAX_ROUNDS; zero passes the state. Reset clears the beat valid
// flags and sets round_count to twelve. Beats in flight at reset are dropped.
module xoodoo_permutation
  import xoodoo_pkg::*;
#(
  parameter int MAX_ROUNDS = MaxRoundsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  state_beat_t state_i,
  output logic        done_o,
  output perm_beat_t  perm_o,
  input  logic        cfg_we_i,
  input  round_cnt_t  cfg_wdata_i
);

  localparam int SumW = RoundCntW + 1;

  round_cnt_t round_count_q;
  round_cnt_t nr_q, nr_d;
  logic       in_valid_q;
  logic       done_q;
  lanes_t     in_lanes_q, in_lanes_d;
  lanes_t     res_lanes_q;
  lanes_t     chain [MAX_ROUNDS+1];
  logic [MAX_ROUNDS-1:0] stage_en;
  logic       accept;

  // The block never holds off a beat.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Unpack the words into lanes and saturate the round count.
  always_comb begin
    in_lanes_d[0]  = state_i.state_words_01[LaneW-1:0];
    in_lanes_d[1]  = state_i.state_words_01[WordW-1:LaneW];
    in_lanes_d[2]  = state_i.state_words_23[LaneW-1:0];
    in_lanes_d[3]  = state_i.state_words_23[WordW-1:LaneW];
    in_lanes_d[4]  = state_i.state_words_45[LaneW-1:0];
    in_lanes_d[5]  = state_i.state_words_45[WordW-1:LaneW];
    in_lanes_d[6]  = state_i.state_words_67[LaneW-1:0];
    in_lanes_d[7]  = state_i.state_words_67[WordW-1:LaneW];
    in_lanes_d[8]  = state_i.state_words_89[LaneW-1:0];
    in_lanes_d[9]  = state_i.state_words_89[WordW-1:LaneW];
    in_lanes_d[10] = state_i.state_words_ab[LaneW-1:0];
    in_lanes_d[11] = state_i.state_words_ab[WordW-1:LaneW];
    if (round_count_q > RoundCntW'(MAX_ROUNDS)) begin
      nr_d = RoundCntW'(MAX_ROUNDS);
    end else begin
      nr_d = round_count_q;
    end
  end

  // Only the last nr rounds of the chain are active: stage k runs when
  // k + nr reaches MAX_ROUNDS.
  always_comb begin
    for (int k = 0; k < MAX_ROUNDS; k++) begin
      stage_en[k] = ({1'b0, nr_q} + SumW'(k)) >= SumW'(MAX_ROUNDS);
    end
  end

  assign chain[0] = in_lanes_q;

  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_round
    xoodoo_round u_round (
      .lanes_i (chain[k]),
      .rc_i    (RoundConsts[ScheduleLen - MAX_ROUNDS + k]),
      .en_i    (stage_en[k]),
      .lanes_o (chain[k+1])
    );
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= RoundCntW'(MaxRoundsDef);
      in_valid_q    <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        round_count_q <= cfg_wdata_i;
      end
      in_valid_q <= accept;
      done_q     <= in_valid_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_lanes_q <= in_lanes_d;
      nr_q       <= nr_d;
    end
    if (in_valid_q) begin
      res_lanes_q <= chain[MAX_ROUNDS];
    end
  end

  assign done_o = done_q;
  assign perm_o.perm_words_01 = {res_lanes_q[1],  res_lanes_q[0]};
  assign perm_o.perm_words_23 = {res_lanes_q[3],  res_lanes_q[2]};
  assign perm_o.perm_words_45 = {res_lanes_q[5],  res_lanes_q[4]};
  assign perm_o.perm_words_67 = {res_lanes_q[7],  res_lanes_q[6]};
  assign perm_o.perm_words_89 = {res_lanes_q[9],  res_lanes_q[8]};
  assign perm_o.perm_words_ab = {res_lanes_q[11], res_lanes_q[10]};

endmodule
